### sv/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared constants and types for the cube map face select core.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfs_pkg;

   localparam int DEFAULT_MAX_FACE_EDGE  = 4096;
   localparam int DEFAULT_COMPONENT_BITS = 16;

   localparam int EDGE_CSR_BITS  = 13;
   localparam int OUT_COORD_BITS = 12;

   localparam logic [EDGE_CSR_BITS-1:0] FACE_EDGE_RESET = 13'd512;

   typedef enum logic [2:0] {
      FACE_LEFT   = 3'd0,
      FACE_FRONT  = 3'd1,
      FACE_RIGHT  = 3'd2,
      FACE_BACK   = 3'd3,
      FACE_TOP    = 3'd4,
      FACE_BOTTOM = 3'd5
   } face_type;

endpackage

`default_nettype wire

### sv/cmfs_select.sv
// ----------------------------------------------------------------------------
// cmfs_select
// Three-stage front end: dominant axis and face numerators, offset to the
// unsigned range, then scale by the face edge.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_select #(
   parameter int COMPONENT_BITS = cmfs_pkg::DEFAULT_COMPONENT_BITS,
   parameter int EDGE_BITS      = 13
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  up_valid,
   output logic                                       up_stall,
   input  wire logic signed [COMPONENT_BITS-1:0]      up_dir_x,
   input  wire logic signed [COMPONENT_BITS-1:0]      up_dir_y,
   input  wire logic signed [COMPONENT_BITS-1:0]      up_dir_z,
   input  wire logic [EDGE_BITS-1:0]                  up_edge,
   output logic                                       dn_valid,
   input  wire logic                                  dn_stall,
   output logic [COMPONENT_BITS+EDGE_BITS:0]          dn_num_u,
   output logic [COMPONENT_BITS+EDGE_BITS:0]          dn_num_v,
   output logic [COMPONENT_BITS:0]                    dn_den,
   output cmfs_pkg::face_type                         dn_face,
   output logic                                       dn_zero,
   output logic [EDGE_BITS-1:0]                       dn_edge
);

   localparam int CW = COMPONENT_BITS;
   localparam int NW = COMPONENT_BITS + EDGE_BITS + 1;

   // handshake
   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   assign adv3     = !v3_ff || !dn_stall;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign up_stall = !adv1;

   // stage 1: magnitudes and face choice
   logic [CW-1:0]        ax, ay, az;
   logic signed [CW:0]   xs, ys, zs;
   cmfs_pkg::face_type   face1_in;
   logic [CW-1:0]        m1_in;
   logic signed [CW:0]   nu1_in, nv1_in;
   logic                 zero1_in;

   assign ax = up_dir_x[CW-1] ? CW'(-up_dir_x) : CW'(up_dir_x);
   assign ay = up_dir_y[CW-1] ? CW'(-up_dir_y) : CW'(up_dir_y);
   assign az = up_dir_z[CW-1] ? CW'(-up_dir_z) : CW'(up_dir_z);
   assign xs = (CW+1)'(up_dir_x);
   assign ys = (CW+1)'(up_dir_y);
   assign zs = (CW+1)'(up_dir_z);
   assign zero1_in = (ax == '0) && (ay == '0) && (az == '0);

   always_comb begin
      if ((ax >= ay) && (ax >= az)) begin
         m1_in  = ax;
         nv1_in = -ys;
         if (!up_dir_x[CW-1] && (up_dir_x != '0)) begin
            face1_in = cmfs_pkg::FACE_RIGHT;
            nu1_in   = -zs;
         end else begin
            face1_in = cmfs_pkg::FACE_LEFT;
            nu1_in   = zs;
         end
      end else if (ay >= az) begin
         m1_in  = ay;
         nu1_in = xs;
         if (!up_dir_y[CW-1] && (up_dir_y != '0)) begin
            face1_in = cmfs_pkg::FACE_TOP;
            nv1_in   = zs;
         end else begin
            face1_in = cmfs_pkg::FACE_BOTTOM;
            nv1_in   = -zs;
         end
      end else begin
         m1_in  = az;
         nv1_in = -ys;
         if (!up_dir_z[CW-1] && (up_dir_z != '0)) begin
            face1_in = cmfs_pkg::FACE_FRONT;
            nu1_in   = xs;
         end else begin
            face1_in = cmfs_pkg::FACE_BACK;
            nu1_in   = -xs;
         end
      end
   end

   cmfs_pkg::face_type   face1_ff, face2_ff, face3_ff;
   logic [CW-1:0]        m1_ff;
   logic signed [CW:0]   nu1_ff, nv1_ff;
   logic                 zero1_ff, zero2_ff, zero3_ff;
   logic [EDGE_BITS-1:0] edge1_ff, edge2_ff, edge3_ff;

   // stage 2: offset numerators by the dominant magnitude
   logic signed [CW+1:0] msum;
   logic signed [CW+1:0] off_u_full, off_v_full;
   logic [CW:0]          off_u2_in, off_v2_in;
   logic [CW:0]          off_u2_ff, off_v2_ff;
   logic [CW:0]          den2_ff, den3_ff;

   assign msum       = signed'((CW+2)'(m1_ff));
   assign off_u_full = (CW+2)'(nu1_ff) + msum;
   assign off_v_full = (CW+2)'(nv1_ff) + msum;
   assign off_u2_in  = (CW+1)'(off_u_full);
   assign off_v2_in  = (CW+1)'(off_v_full);

   // stage 3: scale by edge length
   logic [NW-1:0] num_u3_in, num_v3_in;
   logic [NW-1:0] num_u3_ff, num_v3_ff;

   assign num_u3_in = NW'(off_u2_ff) * NW'(edge2_ff);
   assign num_v3_in = NW'(off_v2_ff) * NW'(edge2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= up_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         face1_ff <= face1_in;
         m1_ff    <= m1_in;
         nu1_ff   <= nu1_in;
         nv1_ff   <= nv1_in;
         zero1_ff <= zero1_in;
         edge1_ff <= up_edge;
      end
      if (adv2) begin
         face2_ff  <= face1_ff;
         off_u2_ff <= off_u2_in;
         off_v2_ff <= off_v2_in;
         den2_ff   <= {m1_ff, 1'b0};
         zero2_ff  <= zero1_ff;
         edge2_ff  <= edge1_ff;
      end
      if (adv3) begin
         face3_ff  <= face2_ff;
         num_u3_ff <= num_u3_in;
         num_v3_ff <= num_v3_in;
         den3_ff   <= den2_ff;
         zero3_ff  <= zero2_ff;
         edge3_ff  <= edge2_ff;
      end
   end

   assign dn_valid = v3_ff;
   assign dn_num_u = num_u3_ff;
   assign dn_num_v = num_v3_ff;
   assign dn_den   = den3_ff;
   assign dn_face  = face3_ff;
   assign dn_zero  = zero3_ff;
   assign dn_edge  = edge3_ff;

endmodule

`default_nettype wire

### sv/cmfs_divide.sv
// ----------------------------------------------------------------------------
// cmfs_divide
// Pipelined restoring divider, one quotient bit per stage for both face
// coordinates, followed by the clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_divide #(
   parameter int COMPONENT_BITS = cmfs_pkg::DEFAULT_COMPONENT_BITS,
   parameter int EDGE_BITS      = 13
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      up_valid,
   output logic                                           up_stall,
   input  wire logic [COMPONENT_BITS+EDGE_BITS:0]         up_num_u,
   input  wire logic [COMPONENT_BITS+EDGE_BITS:0]         up_num_v,
   input  wire logic [COMPONENT_BITS:0]                   up_den,
   input  wire cmfs_pkg::face_type                        up_face,
   input  wire logic                                      up_zero,
   input  wire logic [EDGE_BITS-1:0]                      up_edge,
   output logic                                           dn_valid,
   input  wire logic                                      dn_stall,
   output logic [2:0]                                     dn_face_id,
   output logic [cmfs_pkg::OUT_COORD_BITS-1:0]            dn_face_u,
   output logic [cmfs_pkg::OUT_COORD_BITS-1:0]            dn_face_v,
   output logic                                           dn_zero_direction
);

   localparam int CW = COMPONENT_BITS;
   localparam int QW = EDGE_BITS;
   localparam int NW = COMPONENT_BITS + EDGE_BITS + 1;
   localparam int OW = cmfs_pkg::OUT_COORD_BITS;

   logic [QW-1:0]        valid_ff;
   logic [NW-1:0]        rem_u_ff [QW];
   logic [NW-1:0]        rem_v_ff [QW];
   logic [QW-1:0]        q_u_ff   [QW];
   logic [QW-1:0]        q_v_ff   [QW];
   logic [CW:0]          den_ff   [QW];
   cmfs_pkg::face_type   face_ff  [QW];
   logic [QW-1:0]        zero_ff;
   logic [EDGE_BITS-1:0] edge_ff  [QW];

   logic [NW-1:0]        rem_u_in [QW];
   logic [NW-1:0]        rem_v_in [QW];
   logic [QW-1:0]        q_u_in   [QW];
   logic [QW-1:0]        q_v_in   [QW];

   logic [NW-1:0]        src_rem_u [QW];
   logic [NW-1:0]        src_rem_v [QW];
   logic [QW-1:0]        src_q_u   [QW];
   logic [QW-1:0]        src_q_v   [QW];
   logic [CW:0]          src_den   [QW];
   cmfs_pkg::face_type   src_face  [QW];
   logic [QW-1:0]        src_zero;
   logic [EDGE_BITS-1:0] src_edge  [QW];
   logic [QW-1:0]        src_valid;

   logic [QW:0]          adv;

   logic                 out_valid_ff;
   logic [2:0]           out_face_ff;
   logic [OW-1:0]        out_u_ff, out_v_ff;
   logic                 out_zero_ff;

   // handshake: a stage moves when empty or when the next one moves
   always_comb begin
      adv[QW] = !out_valid_ff || !dn_stall;
      for (int k = QW - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end
   assign up_stall = !adv[0];

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            src_rem_u[k] = up_num_u;
            src_rem_v[k] = up_num_v;
            src_q_u[k]   = '0;
            src_q_v[k]   = '0;
            src_den[k]   = up_den;
            src_face[k]  = up_face;
            src_zero[k]  = up_zero;
            src_edge[k]  = up_edge;
            src_valid[k] = up_valid;
         end else begin
            src_rem_u[k] = rem_u_ff[k-1];
            src_rem_v[k] = rem_v_ff[k-1];
            src_q_u[k]   = q_u_ff[k-1];
            src_q_v[k]   = q_v_ff[k-1];
            src_den[k]   = den_ff[k-1];
            src_face[k]  = face_ff[k-1];
            src_zero[k]  = zero_ff[k-1];
            src_edge[k]  = edge_ff[k-1];
            src_valid[k] = valid_ff[k-1];
         end
      end
   end

   // one quotient bit per stage, most significant first
   always_comb begin
      logic [NW-1:0] trial;
      for (int k = 0; k < QW; k++) begin
         trial = NW'(src_den[k]) << (QW - 1 - k);
         if (src_rem_u[k] >= trial) begin
            rem_u_in[k] = src_rem_u[k] - trial;
            q_u_in[k]   = src_q_u[k] | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_u_in[k] = src_rem_u[k];
            q_u_in[k]   = src_q_u[k];
         end
         if (src_rem_v[k] >= trial) begin
            rem_v_in[k] = src_rem_v[k] - trial;
            q_v_in[k]   = src_q_v[k] | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_v_in[k] = src_rem_v[k];
            q_v_in[k]   = src_q_v[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid[k];
         end
         if (adv[k]) begin
            rem_u_ff[k] <= rem_u_in[k];
            rem_v_ff[k] <= rem_v_in[k];
            q_u_ff[k]   <= q_u_in[k];
            q_v_ff[k]   <= q_v_in[k];
            den_ff[k]   <= src_den[k];
            face_ff[k]  <= src_face[k];
            zero_ff[k]  <= src_zero[k];
            edge_ff[k]  <= src_edge[k];
         end
      end
   end

   // clamp to edge - 1, force the zero vector to the origin of face 0
   logic [QW-1:0] last_edge;
   logic [QW-1:0] clamp_u, clamp_v;
   logic [OW-1:0] out_u_in, out_v_in;
   logic [2:0]    out_face_in;

   assign last_edge = edge_ff[QW-1] - QW'(1);
   assign clamp_u   = (q_u_ff[QW-1] > last_edge) ? last_edge : q_u_ff[QW-1];
   assign clamp_v   = (q_v_ff[QW-1] > last_edge) ? last_edge : q_v_ff[QW-1];

   always_comb begin
      if (zero_ff[QW-1]) begin
         out_u_in    = '0;
         out_v_in    = '0;
         out_face_in = cmfs_pkg::FACE_LEFT;
      end else begin
         out_u_in    = OW'(clamp_u);
         out_v_in    = OW'(clamp_v);
         out_face_in = face_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv[QW]) begin
         out_valid_ff <= valid_ff[QW-1];
      end
      if (adv[QW]) begin
         out_face_ff <= out_face_in;
         out_u_ff    <= out_u_in;
         out_v_ff    <= out_v_in;
         out_zero_ff <= zero_ff[QW-1];
      end
   end

   assign dn_valid          = out_valid_ff;
   assign dn_face_id        = out_face_ff;
   assign dn_face_u         = out_u_ff;
   assign dn_face_v         = out_v_ff;
   assign dn_zero_direction = out_zero_ff;

   // the final remainder stays below the divisor for a nonzero direction
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff[QW-1] && !zero_ff[QW-1] |->
         (rem_u_ff[QW-1] < NW'(den_ff[QW-1])) && (rem_v_ff[QW-1] < NW'(den_ff[QW-1])))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### sv/cubemap_face_select_core.sv
// ----------------------------------------------------------------------------
// cubemap_face_select_core
// Cube map face selection: dominant axis, face id and clamped texel
// coordinates computed exactly in integers.
//
// Usage:
//   req_ channel takes one direction word (dir_x, dir_y, dir_z) per cycle;
//   rsp_ channel returns face_id, face_u, face_v and zero_direction, one
//   word per request, in order. A word moves when valid is high and stall
//   is low. csr_wen with csr_wdata writes the face edge length; write it
//   only while no requests are in flight. Edge 0 is used as 1, an edge
//   above MAX_FACE_EDGE is used as MAX_FACE_EDGE.
//   Throughput is one word per cycle while rsp_stall is low. The stages
//   are three front stages (axis select, offset, edge multiply), one
//   restoring divider stage per quotient bit, and the clamp/output
//   register.
//   Reset empties the pipeline and sets the face edge to 512. While rsp_stall
//   is high the output word holds and the stages behind it fill up; req_stall
//   rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module cubemap_face_select_core #(
   parameter int MAX_FACE_EDGE  = cmfs_pkg::DEFAULT_MAX_FACE_EDGE,
   parameter int COMPONENT_BITS = cmfs_pkg::DEFAULT_COMPONENT_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [cmfs_pkg::EDGE_CSR_BITS-1:0]    csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_dir_x,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_dir_y,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_dir_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [2:0]                                 rsp_face_id,
   output logic [cmfs_pkg::OUT_COORD_BITS-1:0]        rsp_face_u,
   output logic [cmfs_pkg::OUT_COORD_BITS-1:0]        rsp_face_v,
   output logic                                       rsp_zero_direction
);

   localparam int EW = $clog2(MAX_FACE_EDGE + 1);
   localparam int CW = COMPONENT_BITS;
   localparam int NW = CW + EW + 1;

   logic [cmfs_pkg::EDGE_CSR_BITS-1:0] face_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_edge_ff <= cmfs_pkg::FACE_EDGE_RESET;
      end else if (csr_wen) begin
         face_edge_ff <= csr_wdata;
      end
   end

   // saturate the edge into 1..MAX_FACE_EDGE
   logic [31:0]   edge_wide;
   logic [EW-1:0] edge_eff;

   assign edge_wide = 32'(face_edge_ff);

   always_comb begin
      if (edge_wide == 32'd0) begin
         edge_eff = EW'(1);
      end else if (edge_wide > 32'(MAX_FACE_EDGE)) begin
         edge_eff = EW'(MAX_FACE_EDGE);
      end else begin
         edge_eff = EW'(edge_wide);
      end
   end

   logic               mid_valid, mid_stall;
   logic [NW-1:0]      mid_num_u, mid_num_v;
   logic [CW:0]        mid_den;
   cmfs_pkg::face_type mid_face;
   logic               mid_zero;
   logic [EW-1:0]      mid_edge;

   cmfs_select #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .EDGE_BITS      (EW)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_dir_x (req_dir_x),
      .up_dir_y (req_dir_y),
      .up_dir_z (req_dir_z),
      .up_edge  (edge_eff),
      .dn_valid (mid_valid),
      .dn_stall (mid_stall),
      .dn_num_u (mid_num_u),
      .dn_num_v (mid_num_v),
      .dn_den   (mid_den),
      .dn_face  (mid_face),
      .dn_zero  (mid_zero),
      .dn_edge  (mid_edge)
   );

   cmfs_divide #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .EDGE_BITS      (EW)
   ) u_divide (
      .clock             (clock),
      .reset             (reset),
      .up_valid          (mid_valid),
      .up_stall          (mid_stall),
      .up_num_u          (mid_num_u),
      .up_num_v          (mid_num_v),
      .up_den            (mid_den),
      .up_face           (mid_face),
      .up_zero           (mid_zero),
      .up_edge           (mid_edge),
      .dn_valid          (rsp_valid),
      .dn_stall          (rsp_stall),
      .dn_face_id        (rsp_face_id),
      .dn_face_u         (rsp_face_u),
      .dn_face_v         (rsp_face_v),
      .dn_zero_direction (rsp_zero_direction)
   );

   a_zero_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_direction |->
         (rsp_face_id == 3'(cmfs_pkg::FACE_LEFT)) && (rsp_face_u == '0) && (rsp_face_v == '0))
      else $error("zero direction word not at origin of left face");

   a_coord_in_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_face_u) < 32'(edge_eff)) && (32'(rsp_face_v) < 32'(edge_eff)))
      else $error("face coordinate not below face edge");

   a_face_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_face_id <= 3'(cmfs_pkg::FACE_BOTTOM)))
      else $error("face id out of range");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !mid_valid |-> !req_stall)
      else $error("front end stalls with an empty hand-off stage");

endmodule

`default_nettype wire
